>>> rtl/core/bcs_pkg.sv
// Shared types and constants of the battery charge supervisor.
// Used by bcs_cfg_regs, bcs_step and battery_charge_supervisor; no dependencies.
package bcs_pkg;

  // Input transaction kinds.
  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_MODE   = 2'd1,
    KIND_CHARGE = 2'd2
  } kind_t;

  // Sub-states of the battery mode.
  typedef enum logic [2:0] {
    PH_START       = 3'd0,
    PH_MONITOR     = 3'd1,
    PH_CONFIRM     = 3'd2,
    PH_CHARGING    = 3'd3,
    PH_CHARGE_WAIT = 3'd4,
    PH_STABLE_WAIT = 3'd5,
    PH_ERROR       = 3'd6
  } phase_t;

  // Mode request reported with each result.
  typedef enum logic [1:0] {
    NM_STAY  = 2'd0,
    NM_START = 2'd1,
    NM_ERROR = 2'd2,
    NM_IDLE  = 2'd3
  } next_mode_t;

  // Error codes.
  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_LOWBAT = 3'd1,
    ERR_HOT    = 3'd2,
    ERR_OIL    = 3'd3,
    ERR_STBY   = 3'd4
  } err_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMP = 3'd4;

  // Configuration register file contents.
  typedef struct packed {
    logic [15:0] threshold;
    logic [17:0] confirm_ticks;
    logic [17:0] charge_ticks;
    logic [17:0] stable_ticks;
    logic [2:0]  max_attempts;
  } cfg_t;

  // One input transaction.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] batt_level;
    logic        temp_good;
    logic        oil_good;
    logic        ign_on;
    logic        stby_bypass;
  } item_t;

  // Control state apart from the countdown timer.
  typedef struct packed {
    phase_t     phase;
    logic [2:0] attempts;
    logic       charging;
    logic       pump_on;
    logic       active;
  } ctrl_t;

  // One result transaction.
  typedef struct packed {
    next_mode_t next_mode;
    err_t       error_code;
    logic       charging_status;
    logic       pump_drive;
    logic       cool_mode_off;
    logic       deenergize;
    phase_t     phase;
  } res_t;

endpackage

>>> rtl/core/bcs_cfg_regs.sv
// Configuration register file of the battery charge supervisor.
// Depends on bcs_pkg for the register indexes and the cfg_t layout.
module bcs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [bcs_pkg::CFG_DATA_W-1:0] wr_data,
  output bcs_pkg::cfg_t                  cfg
);
  import bcs_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; indexes past the list are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_THRESHOLD:  cfg_nxt.threshold     = wr_data[15:0];
        REG_CONFIRM:    cfg_nxt.confirm_ticks = wr_data[17:0];
        REG_CHARGE:     cfg_nxt.charge_ticks  = wr_data[17:0];
        REG_STABLE:     cfg_nxt.stable_ticks  = wr_data[17:0];
        REG_MAX_ATTEMP: cfg_nxt.max_attempts  = wr_data[2:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  // Register file with documented reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold     <= 16'd0;
      cfg_r.confirm_ticks <= 18'd1000;
      cfg_r.charge_ticks  <= 18'd180000;
      cfg_r.stable_ticks  <= 18'd12000;
      cfg_r.max_attempts  <= 3'd3;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/bcs_step.sv
// Next-state and result logic for one transaction of the supervisor.
// Depends on bcs_pkg; purely combinational, the caller holds all state.
module bcs_step #(
  parameter int unsigned TIMER_BITS = 18
) (
  input  bcs_pkg::cfg_t          cfg,
  input  bcs_pkg::item_t         item,
  input  bcs_pkg::ctrl_t         ctrl,
  input  logic [TIMER_BITS-1:0]  countdown,
  output bcs_pkg::ctrl_t         ctrl_nxt,
  output logic [TIMER_BITS-1:0]  countdown_nxt,
  output bcs_pkg::res_t          res
);
  import bcs_pkg::*;

  localparam logic [63:0] TIMER_MAX = (64'd1 << TIMER_BITS) - 64'd1;

  // Saturate an 18-bit tick count to the timer width.
  function automatic logic [TIMER_BITS-1:0] timer_load(input logic [17:0] v);
    logic [63:0] wide;
    wide = {46'd0, v};
    if (wide > TIMER_MAX) begin
      wide = TIMER_MAX;
    end
    return wide[TIMER_BITS-1:0];
  endfunction

  logic [TIMER_BITS-1:0] cd_dec;
  logic                  expired;
  logic [3:0]            attempt_inc;

  assign cd_dec      = (countdown != '0) ? countdown - 1'b1 : countdown;
  assign expired     = (cd_dec == '0);
  assign attempt_inc = {1'b0, ctrl.attempts} + 4'd1;

  always_comb begin
    ctrl_nxt          = ctrl;
    countdown_nxt     = countdown;
    res.next_mode     = ctrl.active ? NM_STAY : NM_IDLE;
    res.error_code    = ERR_NONE;
    res.cool_mode_off = 1'b0;
    res.deenergize    = 1'b0;

    case (item.kind)
      KIND_MODE: begin
        ctrl_nxt.phase  = PH_START;
        ctrl_nxt.active = 1'b1;
        res.next_mode   = NM_STAY;
      end
      KIND_CHARGE: begin
        ctrl_nxt.phase   = PH_CHARGING;
        ctrl_nxt.pump_on = 1'b1;
        ctrl_nxt.active  = 1'b1;
        res.next_mode    = NM_STAY;
      end
      KIND_TICK: begin
        countdown_nxt = cd_dec;
        if (ctrl.active) begin
          // Phase machine.
          case (ctrl.phase)
            PH_START: begin
              res.deenergize    = 1'b1;
              ctrl_nxt.charging = 1'b0;
              ctrl_nxt.pump_on  = 1'b0;
              ctrl_nxt.attempts = 3'd0;
              ctrl_nxt.phase    = PH_MONITOR;
            end
            PH_MONITOR: begin
              if (item.batt_level < cfg.threshold) begin
                countdown_nxt  = timer_load(cfg.confirm_ticks);
                ctrl_nxt.phase = PH_CONFIRM;
              end else begin
                ctrl_nxt.attempts = 3'd0;
              end
            end
            PH_CONFIRM: begin
              if (!expired) begin
                // Voltage recovered strictly above the threshold: abort.
                if (item.batt_level > cfg.threshold) begin
                  countdown_nxt  = '0;
                  ctrl_nxt.phase = PH_MONITOR;
                end
              end else if (attempt_inc > {1'b0, cfg.max_attempts}) begin
                ctrl_nxt.attempts = 3'd0;
                ctrl_nxt.phase    = PH_ERROR;
              end else begin
                ctrl_nxt.attempts = attempt_inc[2:0];
                res.next_mode     = NM_START;
                ctrl_nxt.phase    = PH_START;
              end
            end
            PH_CHARGING: begin
              countdown_nxt     = timer_load(cfg.charge_ticks);
              ctrl_nxt.charging = 1'b1;
              ctrl_nxt.phase    = PH_CHARGE_WAIT;
            end
            PH_CHARGE_WAIT: begin
              if (expired) begin
                ctrl_nxt.pump_on  = 1'b0;
                res.cool_mode_off = 1'b1;
                ctrl_nxt.charging = 1'b0;
                countdown_nxt     = timer_load(cfg.stable_ticks);
                ctrl_nxt.phase    = PH_STABLE_WAIT;
              end
            end
            PH_STABLE_WAIT: begin
              if (expired) begin
                ctrl_nxt.phase = PH_MONITOR;
              end
            end
            PH_ERROR: begin
              res.error_code = ERR_LOWBAT;
              res.next_mode  = NM_ERROR;
            end
            default: begin
              ctrl_nxt.phase = ctrl.phase;
            end
          endcase

          // Safety checks: temperature takes priority over oil; the standby check, made last, overrides both.
          if (!item.temp_good) begin
            res.error_code = ERR_HOT;
            res.next_mode  = NM_ERROR;
          end else if (ctrl_nxt.pump_on && !item.oil_good) begin
            res.error_code = ERR_OIL;
            res.next_mode  = NM_ERROR;
          end
          if (!item.stby_bypass && ctrl_nxt.charging && item.ign_on) begin
            ctrl_nxt.attempts = 3'd0;
            res.error_code    = ERR_STBY;
            res.next_mode     = NM_ERROR;
          end

          // Leaving the mode on engine start or error.
          if (res.next_mode inside {NM_START, NM_ERROR}) begin
            ctrl_nxt.active = 1'b0;
          end
        end
      end
      default: begin
        ctrl_nxt = ctrl;
      end
    endcase

    res.charging_status = ctrl_nxt.charging;
    res.pump_drive      = ctrl_nxt.pump_on;
    res.phase           = ctrl_nxt.phase;
  end

endmodule

>>> rtl/core/battery_charge_supervisor.sv
// Battery charge supervisor: the top level with input, state and result registers.
// Depends on bcs_pkg, bcs_cfg_regs and bcs_step.
//
// The supervisor takes one transaction per clock cycle while in_stall is low, either
// a 10 ms tick or a mode or charging entry event, and returns exactly one result per
// transaction. A transaction is captured in the input register, its whole step is
// computed combinationally against the held state, and the result lands in the
// output register, which presents it on the result channel. The state is updated
// once per transaction, which sets the sustained rate of one transaction per cycle
// when the result side does not stall.
// Configuration registers are written through the cfg_ port, which is always
// ready, and should only be written while no transaction is in flight.
module battery_charge_supervisor #(
  parameter int unsigned TIMER_BITS = 18
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcs_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_kind,
  input  logic [15:0]                    in_batt_level,
  input  logic                           in_temp_good,
  input  logic                           in_oil_good,
  input  logic                           in_ign_on,
  input  logic                           in_stby_bypass,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_next_mode,
  output logic [2:0]                     out_error_code,
  output logic                           out_charging_status,
  output logic                           out_pump_drive,
  output logic                           out_cool_mode_off,
  output logic                           out_deenergize,
  output logic [2:0]                     out_phase
);
  import bcs_pkg::*;

  cfg_t                  cfg;
  item_t                 item_r;
  logic                  item_vld_r;
  ctrl_t                 ctrl_r;
  ctrl_t                 ctrl_nxt;
  logic [TIMER_BITS-1:0] countdown_r;
  logic [TIMER_BITS-1:0] countdown_nxt;
  res_t                  res_nxt;
  res_t                  res_r;
  logic                  res_vld_r;
  logic                  advance;
  logic                  step_en;

  // Configuration registers; writes are never held off.
  assign cfg_ready = 1'b1;

  bcs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The result register can take a new value when empty or being drained.
  assign advance  = !res_vld_r || !out_stall;
  assign step_en  = item_vld_r && advance;
  assign in_stall = item_vld_r && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (!in_stall) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.kind        <= kind_t'(in_kind);
      item_r.batt_level  <= in_batt_level;
      item_r.temp_good   <= in_temp_good;
      item_r.oil_good    <= in_oil_good;
      item_r.ign_on      <= in_ign_on;
      item_r.stby_bypass <= in_stby_bypass;
    end
  end

  // Step logic.
  bcs_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .cfg           (cfg),
    .item          (item_r),
    .ctrl          (ctrl_r),
    .countdown     (countdown_r),
    .ctrl_nxt      (ctrl_nxt),
    .countdown_nxt (countdown_nxt),
    .res           (res_nxt)
  );

  // Supervisor state, updated once per transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.phase    <= PH_START;
      ctrl_r.attempts <= 3'd0;
      ctrl_r.charging <= 1'b0;
      ctrl_r.pump_on  <= 1'b0;
      ctrl_r.active   <= 1'b0;
      countdown_r     <= '0;
    end else if (step_en) begin
      ctrl_r      <= ctrl_nxt;
      countdown_r <= countdown_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = res_vld_r;
  assign out_next_mode       = res_r.next_mode;
  assign out_error_code      = res_r.error_code;
  assign out_charging_status = res_r.charging_status;
  assign out_pump_drive      = res_r.pump_drive;
  assign out_cool_mode_off   = res_r.cool_mode_off;
  assign out_deenergize      = res_r.deenergize;
  assign out_phase           = res_r.phase;

  // Any reported error must come with an error shutdown request.
  a_err_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> out_next_mode == NM_ERROR)
    else $error("error code reported without error shutdown");

  // The de-energize pulse only comes from the start tick, which moves to monitoring.
  a_deenergize: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_deenergize |-> out_phase == PH_MONITOR && !out_pump_drive
      && !out_charging_status)
    else $error("de-energize pulse outside the start tick");

  // End of charging drops the pump and status and enters the stable wait.
  a_cool_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cool_mode_off |-> out_phase == PH_STABLE_WAIT && !out_pump_drive
      && !out_charging_status)
    else $error("cooling-off pulse with inconsistent charge state");

  // A held input transaction never reaches the state while the result is stalled.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(ctrl_r) && $stable(countdown_r))
    else $error("state changed while the result register was stalled");

endmodule

>>> sim/tb_battery_charge_supervisor.sv
// Self-checking testbench for the battery charge supervisor top level.
// Depends on bcs_pkg and battery_charge_supervisor; drives directed and random traffic
// and checks every result against a behavioral prediction kept in this file.
module tb_battery_charge_supervisor;
  timeunit 1ns;
  timeprecision 1ps;
  import bcs_pkg::*;

  localparam int unsigned TIMER_W     = 18;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_kind;
  logic [15:0]           in_batt_level;
  logic                  in_temp_good;
  logic                  in_oil_good;
  logic                  in_ign_on;
  logic                  in_stby_bypass;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_next_mode;
  logic [2:0]            out_error_code;
  logic                  out_charging_status;
  logic                  out_pump_drive;
  logic                  out_cool_mode_off;
  logic                  out_deenergize;
  logic [2:0]            out_phase;

  // Settings as the block holds them, starting from the reset values.
  logic [15:0] set_threshold    = 16'd0;
  logic [17:0] set_confirm      = 18'd1000;
  logic [17:0] set_charge       = 18'd180000;
  logic [17:0] set_stable       = 18'd12000;
  logic [2:0]  set_max_attempts = 3'd3;

  // Predicted supervisor state.
  phase_t             sup_phase    = PH_START;
  logic [TIMER_W-1:0] sup_timer    = '0;
  logic [2:0]         sup_attempts = 3'd0;
  logic               sup_charging = 1'b0;
  logic               sup_pump     = 1'b0;
  logic               sup_active   = 1'b0;

  // Results predicted for accepted transactions, oldest first.
  res_t supervisor_results_due[$];

  int  fail_count      = 0;
  int  items_sent      = 0;
  int  results_checked = 0;
  int  starts_seen     = 0;
  int  shutdowns_seen  = 0;
  int  charges_done    = 0;
  bit  src_gaps_on     = 1'b1;
  bit  sink_stalls_on  = 1'b1;

  battery_charge_supervisor #(
    .TIMER_BITS(TIMER_W)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_batt_level       (in_batt_level),
    .in_temp_good        (in_temp_good),
    .in_oil_good         (in_oil_good),
    .in_ign_on           (in_ign_on),
    .in_stby_bypass      (in_stby_bypass),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_next_mode       (out_next_mode),
    .out_error_code      (out_error_code),
    .out_charging_status (out_charging_status),
    .out_pump_drive      (out_pump_drive),
    .out_cool_mode_off   (out_cool_mode_off),
    .out_deenergize      (out_deenergize),
    .out_phase           (out_phase)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // One supervisor step: update the predicted state and queue the result it gives.
  // The timer is as wide as the register fields, so a load never saturates.
  function automatic void step_supervisor(input item_t it);
    res_t       r;
    logic       expired;
    logic [3:0] tries;
    r.next_mode     = sup_active ? NM_STAY : NM_IDLE;
    r.error_code    = ERR_NONE;
    r.cool_mode_off = 1'b0;
    r.deenergize    = 1'b0;
    case (it.kind)
      KIND_MODE: begin
        sup_phase   = PH_START;
        sup_active  = 1'b1;
        r.next_mode = NM_STAY;
      end
      KIND_CHARGE: begin
        sup_phase   = PH_CHARGING;
        sup_pump    = 1'b1;
        sup_active  = 1'b1;
        r.next_mode = NM_STAY;
      end
      KIND_TICK: begin
        if (sup_timer != 0) begin
          sup_timer = sup_timer - 1'b1;
        end
        if (sup_active) begin
          expired = (sup_timer == 0);
          case (sup_phase)
            PH_START: begin
              r.deenergize = 1'b1;
              sup_charging = 1'b0;
              sup_pump     = 1'b0;
              sup_attempts = 3'd0;
              sup_phase    = PH_MONITOR;
            end
            PH_MONITOR: begin
              if (it.batt_level < set_threshold) begin
                sup_timer = set_confirm;
                sup_phase = PH_CONFIRM;
              end else begin
                sup_attempts = 3'd0;
              end
            end
            PH_CONFIRM: begin
              if (!expired) begin
                // Voltage strictly above the threshold aborts the confirmation.
                if (it.batt_level > set_threshold) begin
                  sup_timer = '0;
                  sup_phase = PH_MONITOR;
                end
              end else begin
                tries = {1'b0, sup_attempts} + 4'd1;
                if (tries > {1'b0, set_max_attempts}) begin
                  sup_attempts = 3'd0;
                  sup_phase    = PH_ERROR;
                end else begin
                  sup_attempts = tries[2:0];
                  r.next_mode  = NM_START;
                  sup_phase    = PH_START;
                end
              end
            end
            PH_CHARGING: begin
              sup_timer    = set_charge;
              sup_charging = 1'b1;
              sup_phase    = PH_CHARGE_WAIT;
            end
            PH_CHARGE_WAIT: begin
              if (expired) begin
                sup_pump        = 1'b0;
                r.cool_mode_off = 1'b1;
                sup_charging    = 1'b0;
                sup_timer       = set_stable;
                sup_phase       = PH_STABLE_WAIT;
              end
            end
            PH_STABLE_WAIT: begin
              if (expired) begin
                sup_phase = PH_MONITOR;
              end
            end
            PH_ERROR: begin
              r.error_code = ERR_LOWBAT;
              r.next_mode  = NM_ERROR;
            end
            default: ;
          endcase

          // Fault checks: temperature takes priority over oil; the standby check overrides both.
          if (!it.temp_good) begin
            r.error_code = ERR_HOT;
            r.next_mode  = NM_ERROR;
          end else if (sup_pump && !it.oil_good) begin
            r.error_code = ERR_OIL;
            r.next_mode  = NM_ERROR;
          end
          if (!it.stby_bypass && sup_charging && it.ign_on) begin
            sup_attempts = 3'd0;
            r.error_code = ERR_STBY;
            r.next_mode  = NM_ERROR;
          end
          if (r.next_mode inside {NM_START, NM_ERROR}) begin
            sup_active = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.charging_status = sup_charging;
    r.pump_drive      = sup_pump;
    r.phase           = sup_phase;
    supervisor_results_due.push_back(r);
  endfunction

  function automatic item_t tick_item(input logic [15:0] volt, input logic temp_good,
                                      input logic oil_good, input logic ign_on,
                                      input logic bypass_on);
    item_t it;
    it.kind        = KIND_TICK;
    it.batt_level  = volt;
    it.temp_good   = temp_good;
    it.oil_good    = oil_good;
    it.ign_on      = ign_on;
    it.stby_bypass = bypass_on;
    return it;
  endfunction

  // Mode and charging events ignore the sensor fields, so those are random.
  function automatic item_t event_item(input kind_t k);
    item_t it;
    it.kind        = k;
    it.batt_level  = 16'($urandom);
    it.temp_good   = 1'($urandom);
    it.oil_good    = 1'($urandom);
    it.ign_on      = 1'($urandom);
    it.stby_bypass = 1'($urandom);
    return it;
  endfunction

  // Voltage below the threshold with the given percentage, otherwise equal,
  // above, or anywhere in range.
  function automatic logic [15:0] pick_voltage(input int low_pct);
    logic [15:0] v;
    if ($urandom_range(0, 99) < low_pct && set_threshold != 0) begin
      v = 16'($urandom_range(0, set_threshold - 1));
    end else begin
      case ($urandom_range(0, 2))
        0: v = set_threshold;
        1: v = (set_threshold == 16'hFFFF) ? 16'hFFFF :
               16'($urandom_range(set_threshold + 1, 65535));
        default: v = 16'($urandom);
      endcase
    end
    return v;
  endfunction

  // Faults are rare so that charging and confirmation sequences run to the end.
  function automatic item_t random_tick(input int low_pct);
    return tick_item(pick_voltage(low_pct), $urandom_range(0, 24) != 0,
                     $urandom_range(0, 24) != 0, $urandom_range(0, 3) == 0,
                     1'($urandom));
  endfunction

  // Offer one transaction, possibly after an idle burst, and predict its result
  // at the edge where it is accepted.
  task automatic send_item(input item_t it);
    if (src_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= it.kind;
    in_batt_level  <= it.batt_level;
    in_temp_good   <= it.temp_good;
    in_oil_good    <= it.oil_good;
    in_ign_on      <= it.ign_on;
    in_stby_bypass <= it.stby_bypass;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_supervisor(it);
    items_sent++;
  endtask

  // Stop sending and wait until every predicted result has been checked.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (supervisor_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_THRESHOLD:  set_threshold    = val[15:0];
      REG_CONFIRM:    set_confirm      = val;
      REG_CHARGE:     set_charge       = val;
      REG_STABLE:     set_stable       = val;
      REG_MAX_ATTEMP: set_max_attempts = val[2:0];
      default: ;
    endcase
  endtask

  // Settings change only once the block is idle.
  task automatic load_settings(input logic [15:0] thr, input logic [17:0] confirm,
                               input logic [17:0] charge, input logic [17:0] stable,
                               input logic [2:0] attempts);
    wait_results_done();
    write_reg(REG_THRESHOLD, 18'(thr));
    write_reg(REG_CONFIRM, confirm);
    write_reg(REG_CHARGE, charge);
    write_reg(REG_STABLE, stable);
    write_reg(REG_MAX_ATTEMP, 18'(attempts));
    cfg_valid <= 1'b0;
  endtask

  // Random episodes: an optional mode or charging event followed by a run of
  // ticks whose voltage leans low, mixed or high.
  task automatic run_episodes(input int n_items);
    int done_items;
    int len;
    int low_pct;
    int choice;
    done_items = 0;
    while (done_items < n_items) begin
      choice = $urandom_range(0, 9);
      if (choice < 4) begin
        send_item(event_item(KIND_MODE));
        done_items++;
      end else if (choice < 8) begin
        send_item(event_item(KIND_CHARGE));
        done_items++;
      end
      case ($urandom_range(0, 2))
        0: low_pct = 10;
        1: low_pct = 50;
        default: low_pct = 90;
      endcase
      len = $urandom_range(2, 14);
      repeat (len) send_item(random_tick(low_pct));
      done_items += len;
    end
  endtask

  // A full charging cycle that ends in a confirmed low voltage.
  task automatic charge_then_low_cycle();
    send_item(event_item(KIND_CHARGE));
    repeat (5) send_item(tick_item(16'h0000, 1'b1, 1'b1, 1'b0, 1'b0));
  endtask

  // Reset settings: an idle tick, mode entry and the start-phase pulse.
  task automatic test_defaults_and_idle();
    send_item(tick_item(16'h0000, 1'b1, 1'b1, 1'b0, 1'b0));
    send_item(event_item(KIND_MODE));
    send_item(tick_item(16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1));
    send_item(tick_item(16'h0000, 1'b1, 1'b1, 1'b0, 1'b0));
  endtask

  // Shortest timers: a charge cycle that ends in an engine start, then the
  // temperature and oil faults, temperature winning over oil.
  task automatic test_charge_cycle_and_faults();
    load_settings(16'hFFFF, 18'd1, 18'd1, 18'd1, 3'd1);
    charge_then_low_cycle();
    send_item(event_item(KIND_CHARGE));
    send_item(tick_item(16'h1234, 1'b0, 1'b0, 1'b0, 1'b0));
    send_item(event_item(KIND_CHARGE));
    send_item(tick_item(16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0));
  endtask

  // Lowering the attempt limit below the count already reached forces the
  // low-battery error on the next confirmed low voltage.
  task automatic test_attempt_limit_lowered();
    load_settings(16'hFFFF, 18'd1, 18'd1, 18'd1, 3'd0);
    charge_then_low_cycle();
    send_item(tick_item(16'h0000, 1'b1, 1'b1, 1'b0, 1'b0));
  endtask

  // Longest timers: voltage equal to the threshold keeps confirming, one above
  // aborts; standby wins over every other fault.
  task automatic test_recovery_and_standby();
    load_settings(16'h8000, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 3'd7);
    send_item(event_item(KIND_MODE));
    send_item(tick_item(16'h0000, 1'b1, 1'b1, 1'b0, 1'b0));
    send_item(tick_item(16'h7FFF, 1'b1, 1'b1, 1'b0, 1'b0));
    send_item(tick_item(16'h8000, 1'b1, 1'b1, 1'b0, 1'b0));
    send_item(tick_item(16'h8001, 1'b1, 1'b1, 1'b0, 1'b0));
    send_item(event_item(KIND_CHARGE));
    send_item(tick_item(16'h0000, 1'b0, 1'b0, 1'b1, 1'b0));
  endtask

  // Random traffic over several settings; in one phase the sender holds off
  // until every outstanding result has come back.
  task automatic test_random_traffic();
    for (int p = 0; p < 7; p++) begin
      if (p == 3) begin
        load_settings(16'hFFFF, 18'd1, 18'd1, 18'd1, 3'd7);
      end else begin
        load_settings(16'($urandom), 18'($urandom_range(1, 6)), 18'($urandom_range(1, 6)),
                      18'($urandom_range(1, 6)), 3'($urandom_range(0, 7)));
      end
      if (p == 1) begin
        run_episodes(60);
        wait_results_done();
        run_episodes(60);
      end else begin
        run_episodes(120);
      end
    end
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_quiet_tail();
    load_settings(16'($urandom), 18'($urandom_range(1, 4)), 18'($urandom_range(1, 4)),
                  18'($urandom_range(1, 4)), 3'($urandom_range(0, 7)));
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    run_episodes(120);
  endtask

  // Main sequence.
  initial begin : stimulus
    in_valid       <= 1'b0;
    in_kind        <= KIND_TICK;
    in_batt_level  <= '0;
    in_temp_good   <= 1'b1;
    in_oil_good    <= 1'b1;
    in_ign_on      <= 1'b0;
    in_stby_bypass <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_THRESHOLD;
    cfg_data       <= '0;
    rst_n          <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_defaults_and_idle();
    test_charge_cycle_and_faults();
    test_attempt_limit_lowered();
    test_recovery_and_standby();
    test_random_traffic();
    test_quiet_tail();

    wait_results_done();
    repeat (8) @(posedge clk);
    $display("Sent %0d transactions and checked %0d results: %0d engine starts,",
             items_sent, results_checked, starts_seen);
    $display("%0d error shutdowns and %0d completed charge periods.",
             shutdowns_seen, charges_done);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Random stall bursts on the result side.
  initial begin : result_backpressure
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare every accepted result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (supervisor_results_due.size() == 0) begin
        $error("result transaction with nothing outstanding");
        fail_count++;
      end else begin
        want = supervisor_results_due.pop_front();
        results_checked++;
        if (want.next_mode == NM_START) starts_seen++;
        if (want.next_mode == NM_ERROR) shutdowns_seen++;
        if (want.cool_mode_off) charges_done++;
        check_field("next_mode", 4'(want.next_mode), 4'(out_next_mode));
        check_field("error_code", 4'(want.error_code), 4'(out_error_code));
        check_field("charging_status", 4'(want.charging_status), 4'(out_charging_status));
        check_field("pump_drive", 4'(want.pump_drive), 4'(out_pump_drive));
        check_field("cool_mode_off", 4'(want.cool_mode_off), 4'(out_cool_mode_off));
        check_field("deenergize", 4'(want.deenergize), 4'(out_deenergize));
        check_field("phase", 4'(want.phase), 4'(out_phase));
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin : run_limit
    repeat (CYCLE_LIMIT) @(posedge clk);
    $error("run exceeded %0d cycles", CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

endmodule
